// File: rtl/core/lkvc_pkg.sv
package lkvc_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  localparam int IDX_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

  localparam int CAP_BITS   = 4;
  localparam int ADDR_BITS  = 3;
  localparam int REG_CAPACITY = 0;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

  typedef struct packed {
    logic [31:0] lookup_key;
    logic [31:0] fill_value;
  } lkvc_req_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        hit;
    logic        evicted;
  } lkvc_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } lkvc_cmd_t;

endpackage

// File: rtl/core/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output lkvc_pkg::lkvc_cmd_t cmd
);
  import lkvc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start && !busy) begin
            state <= ST_COMPARE;
            busy  <= 1'b1;
          end
        end
        ST_COMPARE: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load    = (state == ST_IDLE) && start && !busy;
    cmd.compare = (state == ST_COMPARE);
    cmd.update  = (state == ST_UPDATE);
  end

endmodule

// File: rtl/core/lkvc_datapath.sv
module lkvc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lkvc_pkg::lkvc_cmd_t         cmd,
  input  logic [lkvc_pkg::CAP_BITS-1:0] capacity,
  input  lkvc_pkg::lkvc_req_t         req,
  output lkvc_pkg::lkvc_rsp_t         rsp
);
  import lkvc_pkg::*;

  logic [KEY_BITS-1:0]   keys [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] vals [MAX_ENTRIES];
  logic [CNT_BITS-1:0]   occ;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] fill_q;
  logic                  match_hit;
  logic [IDX_BITS-1:0]   match_idx;

  logic                  found;
  logic [IDX_BITS-1:0]   found_idx;
  logic [CNT_BITS-1:0]   eff_cap;
  logic [CNT_BITS-1:0]   shift_cnt;
  logic                  evict;
  logic [CNT_BITS-1:0]   occ_next;
  logic [VALUE_BITS-1:0] new_val;

  // Parallel key match; lowest position wins
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = MAX_ENTRIES - 1; j >= 0; j--) begin
      if ((CNT_BITS'(j) < occ) && (keys[j] == key_q)) begin
        found     = 1'b1;
        found_idx = IDX_BITS'(j);
      end
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_BITS'(1);
    end else if (int'(capacity) > MAX_ENTRIES) begin
      eff_cap = CNT_BITS'(MAX_ENTRIES);
    end else begin
      eff_cap = CNT_BITS'(capacity);
    end
  end

  always_comb begin
    evict = 1'b0;
    if (match_hit) begin
      shift_cnt = CNT_BITS'(match_idx);
      occ_next  = occ;
      new_val   = vals[match_idx];
    end else begin
      if (occ >= eff_cap) begin
        shift_cnt = eff_cap - CNT_BITS'(1);
        evict     = 1'b1;
      end else begin
        shift_cnt = occ;
      end
      occ_next = shift_cnt + CNT_BITS'(1);
      new_val  = fill_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.update) begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q  <= KEY_BITS'(req.lookup_key);
      fill_q <= VALUE_BITS'(req.fill_value);
    end
    if (cmd.compare) begin
      match_hit <= found;
      match_idx <= found_idx;
    end
    if (cmd.update) begin
      // Move the chain back up to the shift point and put the entry in front
      for (int j = 1; j < MAX_ENTRIES; j++) begin
        if (CNT_BITS'(j) <= shift_cnt) begin
          keys[j] <= keys[j-1];
          vals[j] <= vals[j-1];
        end
      end
      keys[0]          <= key_q;
      vals[0]          <= new_val;
      rsp.result_value <= 32'(new_val);
      rsp.hit          <= match_hit;
      rsp.evicted      <= evict;
    end
  end

endmodule

// File: rtl/core/lru_key_value_cache_core.sv
// LRU key/value cache, eight entries, fully associative. Pulse start with a
// lookup while busy is low; exactly one result follows on rsp, marked by done
// for a single cycle. A new lookup can be accepted in the cycle that done is
// high. Each lookup registers the request, then does the parallel key compare
// across the recency chain, then shifts the chain and registers the result.
// The receiver cannot stall; capture rsp whenever done is high. Register 0
// (capacity_in_use, 4 bits, reset 8) limits how many entries a miss leaves
// held; write it only while busy is low and no result is pending.
module lru_key_value_cache_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  lkvc_pkg::lkvc_req_t            req,
  output logic                           done,
  output lkvc_pkg::lkvc_rsp_t            rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lkvc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lkvc_pkg::*;

  logic [CAP_BITS-1:0] capacity;
  lkvc_cmd_t           cmd;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (int'(paddr[ADDR_BITS-1:2]) == REG_CAPACITY);
  assign prdata  = reg_sel ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[CAP_BITS-1:0];
    end
  end

  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  lkvc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .capacity (capacity),
    .req      (req),
    .rsp      (rsp)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted lookup did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without a lookup in progress");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done && rsp.hit |-> !rsp.evicted)
    else $error("hit reported an eviction");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

// File: tb/lru_key_value_cache_core_tb.sv
module lru_key_value_cache_core_tb;
  import lkvc_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int REG_UNUSED   = 1;

  typedef enum logic {ROW_LOOKUP, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          reg_index;
    logic [31:0] wdata;
    logic [31:0] key;
    logic [31:0] fill;
    bit          fixed;
    lkvc_rsp_t   fixed_rsp;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  lkvc_req_t            req;
  logic                 done;
  lkvc_rsp_t            rsp;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  // Recency chain as the cache should hold it; position 0 is most recent.
  bit [31:0]     chain_keys [MAX_ENTRIES];
  bit [31:0]     chain_values [MAX_ENTRIES];
  int            chain_len;
  bit [3:0]      capacity_reg;

  lkvc_rsp_t     lookup_results_due [$];
  stim_row_t     directed_rows [$];
  lkvc_rsp_t     due;
  int            mismatches;
  int            cycles;

  lru_key_value_cache_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  // Apply one lookup to the expected chain and return what the cache reports.
  task automatic lru_lookup(input logic [31:0] key, input logic [31:0] fill,
                            output lkvc_rsp_t outcome);
    int          cap;
    int          len;
    int          pos;
    bit          found;
    bit [31:0]   value;
    cap = (capacity_reg == 0) ? 1 :
          (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
    len = chain_len;
    pos = 0;
    found = 1'b0;
    outcome.evicted = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (!found && chain_keys[i] == key) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      value = chain_values[pos];
    end else begin
      value = fill;
      // a lowered capacity trims the chain on this miss, not before
      if (len >= cap) begin
        len = cap - 1;
        outcome.evicted = 1'b1;
      end
      pos = len;
      len++;
    end
    for (int i = pos; i > 0; i--) begin
      chain_keys[i] = chain_keys[i-1];
      chain_values[i] = chain_values[i-1];
    end
    chain_keys[0] = key;
    chain_values[0] = value;
    chain_len = len;
    outcome.result_value = value;
    outcome.hit = found;
  endtask

  // Keep start high across back-to-back lookups; drop it only for a gap.
  task automatic send_lookup(input logic [31:0] key, input logic [31:0] fill,
                             input int gap, input bit fixed,
                             input lkvc_rsp_t fixed_rsp);
    lkvc_rsp_t predicted;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    req.lookup_key <= key;
    req.fill_value <= fill;
    do @(posedge clk); while (busy);
    lru_lookup(key, fill, predicted);
    lookup_results_due.push_back(fixed ? fixed_rsp : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (lookup_results_due.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic reg_write(input int index, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_BITS'(4 * index);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_CAPACITY) capacity_reg = data[3:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic void add_lookup(input logic [31:0] key, input logic [31:0] fill,
                                     input bit fixed, input lkvc_rsp_t fixed_rsp);
    stim_row_t r;
    r.kind = ROW_LOOKUP;
    r.reg_index = REG_CAPACITY;
    r.wdata = '0;
    r.key = key;
    r.fill = fill;
    r.fixed = fixed;
    r.fixed_rsp = fixed_rsp;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_write(input int index, input logic [31:0] data);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.reg_index = index;
    r.wdata = data;
    r.key = '0;
    r.fill = '0;
    r.fixed = 1'b0;
    r.fixed_rsp = '0;
    directed_rows.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (lookup_results_due.size() == 0) begin
        $error("result with no lookup pending: value %h hit %b evicted %b",
               rsp.result_value, rsp.hit, rsp.evicted);
        mismatches++;
      end else begin
        due = lookup_results_due.pop_front();
        if (rsp.result_value !== due.result_value) begin
          $error("result_value: expected %h, actual %h", due.result_value,
                 rsp.result_value);
          mismatches++;
        end
        if (rsp.hit !== due.hit) begin
          $error("hit: expected %b, actual %b", due.hit, rsp.hit);
          mismatches++;
        end
        if (rsp.evicted !== due.evicted) begin
          $error("evicted: expected %b, actual %b", due.evicted, rsp.evicted);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    bit [31:0] key_pool [$];
    bit [31:0] key;
    bit [3:0]  phase_cap [4];
    bit [3:0]  cap;
    int        pool_size;
    int        pick;
    int        gap;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycles = 0;
    chain_len = 0;
    capacity_reg = CAP_RESET;
    phase_cap = '{4'd1, 4'd8, 4'd0, 4'd15};

    // Fresh cache, extremes of key and value, then fill and overflow.
    add_lookup(32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0});
    add_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0});
    add_lookup(32'h0000_0000, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b1, 1'b0});
    add_lookup(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0});
    for (int i = 1; i <= 6; i++) add_lookup(32'(i), 32'hA5A5_0000 | 32'(i), 1'b0, '0);
    add_lookup(32'h0000_0007, 32'h5A5A_5A5A, 1'b1, '{32'h5A5A_5A5A, 1'b0, 1'b1});
    add_lookup(32'h0000_0000, 32'h0000_00FF, 1'b1, '{32'h0000_00FF, 1'b0, 1'b1});
    // Shrink below the current occupancy: a hit keeps the chain length.
    add_write(REG_CAPACITY, 32'd2);
    add_lookup(32'h0000_0007, 32'h0BAD_0BAD, 1'b0, '0);
    add_lookup(32'h8000_0000, 32'h8000_0001, 1'b0, '0);
    // Capacity of zero behaves as one.
    add_write(REG_CAPACITY, 32'd0);
    add_lookup(32'h0000_0007, 32'h0000_1111, 1'b0, '0);
    add_lookup(32'h0000_0001, 32'h0000_2222, 1'b0, '0);
    add_lookup(32'h0000_0001, 32'h0000_3333, 1'b0, '0);
    // Capacity above the entry count is clamped; the unused address is ignored.
    add_write(REG_CAPACITY, 32'hFFFF_FFFF);
    add_write(REG_UNUSED, 32'd1);
    add_lookup(32'h0000_0002, 32'h0000_4444, 1'b0, '0);
    add_lookup(32'h0000_0003, 32'h0000_5555, 1'b0, '0);
    add_lookup(32'h0000_0001, 32'h0000_6666, 1'b0, '0);
    add_write(REG_CAPACITY, 32'd8);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        reg_write(directed_rows[i].reg_index, directed_rows[i].wdata);
      end else begin
        send_lookup(directed_rows[i].key, directed_rows[i].fill, 0,
                    directed_rows[i].fixed, directed_rows[i].fixed_rsp);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      cap = (ph < 4) ? phase_cap[ph] : 4'($urandom_range(0, 15));
      wait_idle();
      reg_write(REG_CAPACITY, {28'($urandom_range(0, 32'h0FFF_FFFF)), cap});
      if ($urandom_range(0, 1) == 1) reg_write(REG_UNUSED, $urandom);
      key_pool.delete();
      pool_size = $urandom_range(1, 12);
      for (int k = 0; k < pool_size; k++) key_pool.push_back($urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off until the cache has answered everything sent so far
        if (ph == 1 && n == PHASE_ITEMS / 2) wait_idle();
        pick = $urandom_range(0, 19);
        key = key_pool[$urandom_range(0, pool_size - 1)];
        if (pick >= 17) key = $urandom;
        else if (pick >= 14) key = key ^ (32'h1 << $urandom_range(0, 31));
        gap = 0;
        if (ph < PHASES - 1 && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
        send_lookup(key, $urandom, gap, 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lkvc_datapath.sv
rtl/core/lru_key_value_cache_core.sv
tb/lru_key_value_cache_core_tb.sv
